[rtl/etpq_pkg.sv]
// Shared constants, types and codes of the event time priority queue.
package etpq_pkg;

   localparam int NUM_OBJECTS = 64;
   localparam int TIME_BITS   = 32;
   localparam int OBJ_BITS    = $clog2(NUM_OBJECTS);
   localparam int COUNT_BITS  = $clog2(NUM_OBJECTS + 1);
   localparam int PFX_LEVELS  = $clog2(NUM_OBJECTS);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_REJECT   = 2'd2,
      STATUS_BACKWARD = 2'd3
   } status_type;

   typedef enum logic {
      ACTION_NOTIFY = 1'b0,
      ACTION_POP    = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_EVAL,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      logic                 valid;
      logic [OBJ_BITS-1:0]  obj;
      logic [TIME_BITS-1:0] time_val;
   } entry_type;

   typedef struct packed {
      cell_op_type          op;
      logic                 move;
      logic [OBJ_BITS-1:0]  key_obj;
      logic [TIME_BITS-1:0] key_time;
   } cell_cmd_type;

   typedef struct packed {
      logic lt;
      logic match;
      logic le;
   } cell_flags_type;

endpackage

[rtl/etpq_cell.sv]
// One queue cell: holds one entry and shifts it to or from its neighbours.
module etpq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  etpq_pkg::cell_cmd_type  cmd,
   input  etpq_pkg::entry_type     left_entry,
   input  etpq_pkg::entry_type     right_entry,
   input  logic                    left_lt,
   input  logic                    past_match,
   output etpq_pkg::entry_type     entry,
   output etpq_pkg::cell_flags_type flags
);

   logic                           valid_ff, valid_in;
   logic [etpq_pkg::OBJ_BITS-1:0]  obj_ff, obj_in;
   logic [etpq_pkg::TIME_BITS-1:0] time_ff, time_in;
   logic                           lt_ff, match_ff, le_ff;

   always_comb begin
      valid_in = valid_ff;
      obj_in   = obj_ff;
      time_in  = time_ff;
      unique case (cmd.op)
         etpq_pkg::CELL_HOLD, etpq_pkg::CELL_EVAL: begin
         end
         etpq_pkg::CELL_INSERT: begin
            if (!lt_ff) begin
               if (left_lt) begin
                  valid_in = 1'b1;
                  obj_in   = cmd.key_obj;
                  time_in  = cmd.key_time;
               end else if (!(cmd.move && past_match)) begin
                  valid_in = left_entry.valid;
                  obj_in   = left_entry.obj;
                  time_in  = left_entry.time_val;
               end
            end
         end
         etpq_pkg::CELL_POP: begin
            valid_in = right_entry.valid;
            obj_in   = right_entry.obj;
            time_in  = right_entry.time_val;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      obj_ff  <= obj_in;
      time_ff <= time_in;
   end

   // Comparisons against the key are registered in the compare step, ahead of the shift.
   always_ff @(posedge clock) begin
      if (cmd.op == etpq_pkg::CELL_EVAL) begin
         lt_ff    <= valid_ff && (time_ff < cmd.key_time);
         match_ff <= valid_ff && (obj_ff == cmd.key_obj);
         le_ff    <= time_ff <= cmd.key_time;
      end
   end

   assign entry.valid    = valid_ff;
   assign entry.obj      = obj_ff;
   assign entry.time_val = time_ff;
   assign flags.lt       = lt_ff;
   assign flags.match    = match_ff;
   assign flags.le       = le_ff;

endmodule

[rtl/event_time_priority_queue.sv]
// Top level of the event time priority queue: control, state and a row of queue cells.
//
//   channel  ports                                           direction
//   req      req_valid req_stall req_action req_object_id    in
//            req_event_time
//   rsp      rsp_valid rsp_stall rsp_status rsp_popped_object out
//            rsp_popped_time rsp_sim_complete
//   csr      csr_write_enable csr_write_data                 in
//
// Every word passes capture, then a compare step in which all cells test their entries
// against the key, then a shift step that updates the row.
// The shift step waits while an earlier result word is held by rsp_stall.
// Reset empties the queue at once, clears the time and sets end_time to all ones.
module event_time_priority_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [etpq_pkg::OBJ_BITS-1:0]   req_object_id,
   input  logic [etpq_pkg::TIME_BITS-1:0]  req_event_time,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [etpq_pkg::OBJ_BITS-1:0]   rsp_popped_object,
   output logic [etpq_pkg::TIME_BITS-1:0]  rsp_popped_time,
   output logic                            rsp_sim_complete,
   input  logic                            csr_write_enable,
   input  logic [etpq_pkg::TIME_BITS-1:0]  csr_write_data
);

   localparam int N = etpq_pkg::NUM_OBJECTS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY
   } state_type;

   state_type                          state_ff;
   logic                               action_ff;
   logic [etpq_pkg::OBJ_BITS-1:0]      obj_ff;
   logic [etpq_pkg::TIME_BITS-1:0]     key_time_ff;
   logic [etpq_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic [N-1:0]                       pending_ff, pending_in;
   logic [etpq_pkg::TIME_BITS-1:0]     cur_time_ff, cur_time_in;
   logic                               done_ff, done_in;
   logic [etpq_pkg::TIME_BITS-1:0]     end_time_ff;
   logic                               rsp_valid_ff;
   etpq_pkg::status_type               status_ff, status_in;
   logic [etpq_pkg::OBJ_BITS-1:0]      pobj_ff, pobj_in;
   logic [etpq_pkg::TIME_BITS-1:0]     ptime_ff, ptime_in;
   logic                               done_out_ff;

   etpq_pkg::cell_cmd_type             cmd;
   etpq_pkg::entry_type                cell_entry [N];
   etpq_pkg::cell_flags_type           cell_flags [N];
   logic [N-1:0]                       lt_vec, match_vec, le_vec, before_vec;
   logic [N-1:0]                       pfx [etpq_pkg::PFX_LEVELS+1];
   logic                               apply_go, is_move, reject;
   etpq_pkg::entry_type                head;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         lt_vec[i]    = cell_flags[i].lt;
         match_vec[i] = cell_flags[i].match;
         le_vec[i]    = cell_flags[i].le;
      end
   end

   // Log-depth prefix OR: a cell lies past the moved entry if a match sits below it.
   always_comb begin
      pfx[0] = match_vec;
      for (int l = 0; l < etpq_pkg::PFX_LEVELS; l++) begin
         for (int i = 0; i < N; i++) begin
            if (i >= (1 << l)) begin
               pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
            end else begin
               pfx[l+1][i] = pfx[l][i];
            end
         end
      end
      before_vec = {pfx[etpq_pkg::PFX_LEVELS][N-2:0], 1'b0};
   end

   assign head     = cell_entry[0];
   assign apply_go = (state_ff == ST_APPLY) && !(rsp_valid_ff && rsp_stall);
   assign is_move  = pending_ff[obj_ff];
   assign reject   = is_move ? (!(|match_vec) || (|(match_vec & le_vec)))
                             : (count_ff == etpq_pkg::COUNT_BITS'(N));

   always_comb begin
      cmd.op       = etpq_pkg::CELL_HOLD;
      cmd.move     = is_move;
      cmd.key_obj  = obj_ff;
      cmd.key_time = key_time_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      cur_time_in  = cur_time_ff;
      done_in      = done_ff;
      status_in    = etpq_pkg::STATUS_OK;
      pobj_in      = '0;
      ptime_in     = '0;
      if (state_ff == ST_EVAL) begin
         cmd.op = etpq_pkg::CELL_EVAL;
      end else if (apply_go) begin
         if (action_ff == etpq_pkg::ACTION_NOTIFY) begin
            if (reject) begin
               status_in = etpq_pkg::STATUS_REJECT;
            end else begin
               cmd.op             = etpq_pkg::CELL_INSERT;
               pending_in[obj_ff] = 1'b1;
               if (!is_move) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end else if (count_ff == '0) begin
            status_in = etpq_pkg::STATUS_EMPTY;
         end else begin
            cmd.op               = etpq_pkg::CELL_POP;
            count_in             = count_ff - 1'b1;
            pending_in[head.obj] = 1'b0;
            pobj_in              = head.obj;
            ptime_in             = head.time_val;
            if (head.time_val < cur_time_ff) begin
               status_in = etpq_pkg::STATUS_BACKWARD;
            end else if (head.time_val != cur_time_ff) begin
               cur_time_in = head.time_val;
               done_in     = head.time_val >= end_time_ff;
            end
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      etpq_pkg::entry_type left_e, right_e;
      logic                left_l;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_l = 1'b1;
      end else begin : g_inner
         assign left_e = cell_entry[i-1];
         assign left_l = lt_vec[i-1];
      end
      if (i == N - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_body
         assign right_e = cell_entry[i+1];
      end
      etpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_lt     (left_l),
         .past_match  (before_vec[i]),
         .entry       (cell_entry[i]),
         .flags       (cell_flags[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pending_ff   <= '0;
         cur_time_ff  <= '0;
         done_ff      <= 1'b0;
         end_time_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         pending_ff  <= pending_in;
         cur_time_ff <= cur_time_in;
         done_ff     <= done_in;
         if (csr_write_enable) begin
            end_time_ff <= csr_write_data;
         end
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (apply_go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (state_ff == ST_IDLE && req_valid) begin
         action_ff   <= req_action;
         obj_ff      <= req_object_id;
         key_time_ff <= req_event_time;
      end
      if (apply_go) begin
         status_ff   <= status_in;
         pobj_ff     <= pobj_in;
         ptime_ff    <= ptime_in;
         done_out_ff <= done_in;
      end
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_popped_object = pobj_ff;
   assign rsp_popped_time   = ptime_ff;
   assign rsp_sim_complete  = done_out_ff;

endmodule

[rtl/etpq_checker.sv]
// Port-level checks for the event time priority queue and their binding.
module etpq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_status,
   input logic [etpq_pkg::OBJ_BITS-1:0]   rsp_popped_object,
   input logic [etpq_pkg::TIME_BITS-1:0]  rsp_popped_time
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result word dropped while stalled.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Request taken again straight after an accepted word.");

   a_no_pop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == etpq_pkg::STATUS_EMPTY ||
                    rsp_status == etpq_pkg::STATUS_REJECT)
      |-> rsp_popped_object == '0 && rsp_popped_time == '0)
      else $error("Popped fields set on a word that removed nothing.");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result word present straight after reset.");

endmodule

bind event_time_priority_queue etpq_checker u_etpq_checker (.*);

[dv/tb_event_time_priority_queue.sv]
// Self-checking testbench for the event time priority queue: directed table, then random phases.
module tb_event_time_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned PHASE_WORDS  = 300;
   localparam int unsigned PHASE_COUNT  = 6;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned SETTLE_TICKS = 12;

   typedef struct packed {
      logic [etpq_pkg::OBJ_BITS-1:0]  obj;
      logic [etpq_pkg::TIME_BITS-1:0] stamp;
   } queued_event_type;

   typedef struct packed {
      etpq_pkg::status_type           status;
      logic [etpq_pkg::OBJ_BITS-1:0]  obj;
      logic [etpq_pkg::TIME_BITS-1:0] stamp;
      logic                           done;
   } outcome_type;

   typedef struct {
      etpq_pkg::action_type           act;
      logic [etpq_pkg::OBJ_BITS-1:0]  obj;
      logic [etpq_pkg::TIME_BITS-1:0] stamp;
      bit                             typed;
      outcome_type                    want;
   } stimulus_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_action;
   logic [etpq_pkg::OBJ_BITS-1:0]   req_object_id;
   logic [etpq_pkg::TIME_BITS-1:0]  req_event_time;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [1:0]                      rsp_status;
   logic [etpq_pkg::OBJ_BITS-1:0]   rsp_popped_object;
   logic [etpq_pkg::TIME_BITS-1:0]  rsp_popped_time;
   logic                            rsp_sim_complete;
   logic                            csr_write_enable;
   logic [etpq_pkg::TIME_BITS-1:0]  csr_write_data;

   queued_event_type                   event_order[$];
   logic [etpq_pkg::NUM_OBJECTS-1:0]   is_pending;
   logic [etpq_pkg::TIME_BITS-1:0]     sim_now;
   logic                               sim_done;
   logic [etpq_pkg::TIME_BITS-1:0]     stop_time;

   outcome_type           expected_results[$];
   outcome_type           due_result;
   stimulus_row_type      directed_rows[$];

   bit                    quiet_phase = 1'b0;
   bit                    long_hold_done = 1'b0;
   int unsigned           words_in = 0;
   int unsigned           words_out = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           status_seen[4] = '{0, 0, 0, 0};
   int unsigned           done_seen = 0;
   int unsigned           peak_depth = 0;
   int unsigned           settings_used = 1;

   event_time_priority_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_object_id     (req_object_id),
      .req_event_time    (req_event_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_object (rsp_popped_object),
      .rsp_popped_time   (rsp_popped_time),
      .rsp_sim_complete  (rsp_sim_complete),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d words outstanding.",
                  cycle_count, expected_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic outcome_type apply_word(input etpq_pkg::action_type act,
                                              input logic [etpq_pkg::OBJ_BITS-1:0] obj,
                                              input logic [etpq_pkg::TIME_BITS-1:0] stamp);
      outcome_type      res;
      queued_event_type head;
      queued_event_type fresh;
      int               idx;
      int               slot;
      res.status = etpq_pkg::STATUS_OK;
      res.obj    = '0;
      res.stamp  = '0;
      res.done   = 1'b0;
      if (act == etpq_pkg::ACTION_NOTIFY) begin
         idx = -1;
         if (is_pending[obj]) begin
            foreach (event_order[i])
               if (idx < 0 && event_order[i].obj == obj) idx = i;
            if (idx < 0 || !(stamp < event_order[idx].stamp))
               res.status = etpq_pkg::STATUS_REJECT;
            else
               event_order.delete(idx);
         end
         if (res.status == etpq_pkg::STATUS_OK && event_order.size() >= etpq_pkg::NUM_OBJECTS)
            res.status = etpq_pkg::STATUS_REJECT;
         if (res.status == etpq_pkg::STATUS_OK) begin
            slot = 0;
            while (slot < event_order.size() && event_order[slot].stamp < stamp)
               slot++;
            fresh.obj   = obj;
            fresh.stamp = stamp;
            event_order.insert(slot, fresh);
            is_pending[obj] = 1'b1;
         end
      end else if (event_order.size() == 0) begin
         res.status = etpq_pkg::STATUS_EMPTY;
      end else begin
         head = event_order[0];
         event_order.delete(0);
         is_pending[head.obj] = 1'b0;
         res.obj   = head.obj;
         res.stamp = head.stamp;
         if (head.stamp < sim_now) begin
            res.status = etpq_pkg::STATUS_BACKWARD;
         end else if (head.stamp != sim_now) begin
            sim_now  = head.stamp;
            sim_done = (sim_now >= stop_time);
         end
      end
      res.done = sim_done;
      status_seen[res.status]++;
      if (res.done) done_seen++;
      if (event_order.size() > peak_depth) peak_depth = event_order.size();
      return res;
   endfunction

   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [etpq_pkg::TIME_BITS-1:0] pick_stamp(input bit allow_top);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (allow_top && r < 3) return '1;
      if (r < 50) return sim_now + $urandom_range(1, 2000);
      if (r < 70) return sim_now + $urandom_range(0, 3);
      if (r < 82) return sim_now + $urandom_range(0, 20);
      if (r < 94) return sim_now - $urandom_range(1, 500);
      return $urandom;
   endfunction

   task automatic send_word(input etpq_pkg::action_type act,
                            input logic [etpq_pkg::OBJ_BITS-1:0] obj,
                            input logic [etpq_pkg::TIME_BITS-1:0] stamp, input bit typed,
                            input outcome_type want);
      int unsigned gap;
      outcome_type predicted;
      gap = idle_span();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_object_id  <= obj;
      req_event_time <= stamp;
      do @(posedge clock); while (req_stall);
      predicted = apply_word(act, obj, stamp);
      expected_results.push_back(typed ? want : predicted);
      words_in++;
   endtask

   task automatic offer_random_word(input int unsigned pop_pct, input bit allow_top);
      etpq_pkg::action_type           act;
      logic [etpq_pkg::OBJ_BITS-1:0]  obj;
      logic [etpq_pkg::TIME_BITS-1:0] stamp;
      queued_event_type               target;
      outcome_type                    blank;
      int unsigned                    r;
      int unsigned                    span;
      blank = '0;
      act   = ($urandom_range(0, 99) < pop_pct) ? etpq_pkg::ACTION_POP
                                                : etpq_pkg::ACTION_NOTIFY;
      obj   = etpq_pkg::OBJ_BITS'($urandom_range(0, etpq_pkg::NUM_OBJECTS - 1));
      stamp = pick_stamp(allow_top);
      if (act == etpq_pkg::ACTION_NOTIFY && event_order.size() != 0 &&
          $urandom_range(0, 99) < 35) begin
         target = event_order[$urandom_range(0, event_order.size() - 1)];
         obj    = target.obj;
         r      = $urandom_range(0, 99);
         if (r < 60) begin
            span  = (target.stamp < 300) ? target.stamp : 300;
            stamp = (span == 0) ? target.stamp : target.stamp - $urandom_range(1, span);
         end else if (r < 80) begin
            stamp = target.stamp;
         end else begin
            stamp = target.stamp + $urandom_range(1, 100);
         end
      end
      send_word(act, obj, stamp, 1'b0, blank);
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_end_time(input logic [etpq_pkg::TIME_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      stop_time = value;
      settings_used++;
   endtask

   task automatic add_row(input etpq_pkg::action_type act,
                          input logic [etpq_pkg::OBJ_BITS-1:0] obj,
                          input logic [etpq_pkg::TIME_BITS-1:0] stamp, input bit typed,
                          input etpq_pkg::status_type status,
                          input logic [etpq_pkg::OBJ_BITS-1:0] pobj,
                          input logic [etpq_pkg::TIME_BITS-1:0] ptime, input logic done);
      stimulus_row_type row;
      row.act          = act;
      row.obj          = obj;
      row.stamp        = stamp;
      row.typed        = typed;
      row.want.status  = status;
      row.want.obj     = pobj;
      row.want.stamp   = ptime;
      row.want.done    = done;
      directed_rows.push_back(row);
   endtask

   // Receiver: random stalls, plus one long hold-off so that the block backs up.
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         hold = idle_span();
         if (!long_hold_done && words_out >= 400) begin
            hold = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (expected_results.size() == 0) begin
            $error("Unexpected result word: status %0d object %0d time %0d complete %0d",
                   rsp_status, rsp_popped_object, rsp_popped_time, rsp_sim_complete);
            mismatch_count++;
         end else begin
            due_result = expected_results[0];
            expected_results.delete(0);
            if (rsp_status !== due_result.status) begin
               $error("rsp_status: expected %0d, got %0d", due_result.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_popped_object !== due_result.obj) begin
               $error("rsp_popped_object: expected %0d, got %0d",
                      due_result.obj, rsp_popped_object);
               mismatch_count++;
            end
            if (rsp_popped_time !== due_result.stamp) begin
               $error("rsp_popped_time: expected %0d, got %0d",
                      due_result.stamp, rsp_popped_time);
               mismatch_count++;
            end
            if (rsp_sim_complete !== due_result.done) begin
               $error("rsp_sim_complete: expected %0d, got %0d",
                      due_result.done, rsp_sim_complete);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      logic [etpq_pkg::TIME_BITS-1:0] phase_end;
      int unsigned                    pop_pct;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = etpq_pkg::ACTION_NOTIFY;
      req_object_id    = '0;
      req_event_time   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      event_order.delete();
      is_pending = '0;
      sim_now    = '0;
      sim_done   = 1'b0;
      stop_time  = '1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the end time at its reset value.
      add_row(etpq_pkg::ACTION_POP,    0,  0,            1, etpq_pkg::STATUS_EMPTY,  0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 63, 32'hFFFFFFFF, 1, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 0,  0,            1, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 63, 32'hFFFFFFFF, 1, etpq_pkg::STATUS_REJECT, 0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 0,  0,            1, etpq_pkg::STATUS_REJECT, 0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 5,  100,          0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 6,  100,          0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 42, 32'h55555555, 0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 21, 32'hAAAAAAAA, 0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 5,  50,           0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 5,  60,           1, etpq_pkg::STATUS_REJECT, 0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 63, 200,          0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_POP,    0,  0,            1, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_POP,    0,  0,            0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 7,  10,           0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_POP,    0,  0,            1, etpq_pkg::STATUS_BACKWARD,
              7, 10, 0);
      add_row(etpq_pkg::ACTION_POP,    0,  0,            0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_NOTIFY, 9,  100,          0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_POP,    0,  0,            0, etpq_pkg::STATUS_OK,     0, 0, 0);
      add_row(etpq_pkg::ACTION_POP,    0,  0,            0, etpq_pkg::STATUS_OK,     0, 0, 0);

      foreach (directed_rows[k])
         send_word(directed_rows[k].act, directed_rows[k].obj, directed_rows[k].stamp,
                   directed_rows[k].typed, directed_rows[k].want);
      drain_and_settle();

      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         unique case (phase)
            0: begin
               phase_end = '0;
               pop_pct   = 45;
            end
            1: begin
               phase_end = sim_now + $urandom_range(1000, 30000);
               pop_pct   = 40;
            end
            2: begin
               phase_end = $urandom;
               pop_pct   = 50;
            end
            3: begin
               phase_end = sim_now + $urandom_range(1000, 30000);
               pop_pct   = 10;
            end
            4: begin
               phase_end = sim_now;
               pop_pct   = 55;
            end
            default: begin
               phase_end = '1;
               pop_pct   = 60;
            end
         endcase
         quiet_phase = (phase == 3);
         write_end_time(phase_end);
         repeat (PHASE_WORDS) offer_random_word(pop_pct, phase == PHASE_COUNT - 1);
         drain_and_settle();
      end

      $display("Covered %0d request words and %0d result words over %0d end-time settings,",
               words_in, words_out, settings_used);
      $display("queue depth up to %0d; ok %0d, empty %0d, rejected %0d, backward %0d, complete %0d.",
               peak_depth, status_seen[etpq_pkg::STATUS_OK],
               status_seen[etpq_pkg::STATUS_EMPTY], status_seen[etpq_pkg::STATUS_REJECT],
               status_seen[etpq_pkg::STATUS_BACKWARD], done_seen);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
